// File: hdl/sqs_pkg.sv
// Shared types and codes for the stack/queue store.
package sqs_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_DUMP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_EMPTY      = 2'd1,
		STAT_FULL       = 2'd2,
		STAT_DUMP_EMPTY = 2'd3
	} status_t;

	// per-cycle operation applied to every cell of the row
	typedef enum logic [2:0] {
		OP_HOLD     = 3'd0,
		OP_SHIFT_DN = 3'd1, // push at top
		OP_SHIFT_UP = 3'd2, // pop top
		OP_APPEND   = 3'd3, // push at bottom
		OP_ROTATE   = 3'd4  // top moves to bottom, rest move up
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] top_data;
	} cell_ctl_t;

	typedef struct packed {
		logic                      valid;
		logic signed [DATA_W-1:0] data;
	} cell_link_t;

endpackage

// File: hdl/sqs_in_if.sv
// Request channel: operation kind and push value.
interface sqs_in_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic signed [sqs_pkg::DATA_W-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

// File: hdl/sqs_out_if.sv
// Result channel: entry value, status code and last-beat flag.
interface sqs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [sqs_pkg::DATA_W-1:0] data;
	logic [1:0]                        status;
	logic                              last;

	modport source (output valid, data, status, last, input ready);
	modport sink   (input valid, data, status, last, output ready);
endinterface

// File: hdl/sqs_cell.sv
// One storage cell of the row: an entry and its occupied flag.
module sqs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sqs_pkg::cell_ctl_t  ctl,
	input  sqs_pkg::cell_link_t up,
	input  sqs_pkg::cell_link_t dn,
	output sqs_pkg::cell_link_t cur
);

	logic                              valid_q;
	logic signed [sqs_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				sqs_pkg::OP_SHIFT_DN: valid_q <= up.valid;
				sqs_pkg::OP_SHIFT_UP: valid_q <= dn.valid;
				sqs_pkg::OP_APPEND: begin
					if (!valid_q && up.valid) valid_q <= 1'b1;
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			sqs_pkg::OP_SHIFT_DN: data_q <= up.data;
			sqs_pkg::OP_SHIFT_UP: data_q <= dn.data;
			sqs_pkg::OP_APPEND: begin
				if (!valid_q && up.valid) data_q <= ctl.value;
			end
			sqs_pkg::OP_ROTATE: begin
				// last occupied cell takes the old top
				if (valid_q) data_q <= dn.valid ? dn.data : ctl.top_data;
			end
			default: data_q <= data_q;
		endcase
	end

	assign cur.valid = valid_q;
	assign cur.data  = data_q;

endmodule

// File: hdl/stack_queue_store_core.sv
// Top level of the bounded stack/queue store built as a row of cells.
//
// Usage:
//   in  : request beats {kind, value}; kind is push, pop, peek or dump.
//   out : result beats {data, status, last}; last marks an item's final beat.
//   cfg_we/cfg_wdata : writes the mode bit (0 stack, 1 queue); write it only
//   while no item is in flight.
// Storage is a row of DEPTH cells, cell 0 holding the top entry. Push in
// stack mode shifts the row down, pop shifts it up, push in queue mode fills
// the first free cell. Dump rotates the row once per beat: the top is sent
// and moves to the bottom, so after count beats the order is restored.
// The result of an item is registered and is on out in the cycle after its
// input beat. Push, pop and peek give one result beat each; a dump of n
// entries gives n beats (one rotation each) and holds in.ready low meanwhile.
// Reset empties the store (occupied flags and count cleared, mode = stack);
// entry contents are not reset. A stall on out holds the result register
// and blocks both new input beats and dump progress; nothing is dropped.
module stack_queue_store_core #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	sqs_in_if.sink   in,
	sqs_out_if.source out,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t     state_q, state_nxt;
	logic       mode_q;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [CNT_W-1:0] rem_q, rem_nxt;

	logic                              out_vld_q;
	logic signed [sqs_pkg::DATA_W-1:0] out_data_q;
	sqs_pkg::status_t                  out_stat_q;
	logic                              out_last_q;

	logic                              ld;
	logic signed [sqs_pkg::DATA_W-1:0] o_data;
	sqs_pkg::status_t                  o_stat;
	logic                              o_last;

	sqs_pkg::cell_ctl_t  ctl;
	sqs_pkg::cell_link_t link [DEPTH];
	logic [DEPTH-1:0]    vld_vec;

	logic out_free, acc, dump_step, empty, full;
	sqs_pkg::kind_t kind;

	assign out_free  = !out_vld_q || out.ready;
	assign in.ready  = (state_q == ST_IDLE) && out_free;
	assign acc       = in.valid && in.ready;
	assign dump_step = (state_q == ST_DUMP) && out_free;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign kind      = sqs_pkg::kind_t'(in.kind);

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// operation decode and result formation
	always_comb begin
		ctl.op       = sqs_pkg::OP_HOLD;
		ctl.value    = in.value;
		ctl.top_data = link[0].data;
		ld           = 1'b0;
		o_data       = '0;
		o_stat       = sqs_pkg::STAT_OK;
		o_last       = 1'b1;
		count_nxt    = count_q;
		rem_nxt      = rem_q;
		state_nxt    = state_q;
		if (acc) begin
			ld = 1'b1;
			unique case (kind)
				sqs_pkg::KIND_PUSH: begin
					if (full) begin
						o_stat = sqs_pkg::STAT_FULL;
					end else begin
						// empty store always takes the push at the top
						ctl.op    = (mode_q && !empty) ? sqs_pkg::OP_APPEND
						                               : sqs_pkg::OP_SHIFT_DN;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				sqs_pkg::KIND_POP: begin
					if (empty) begin
						o_stat = sqs_pkg::STAT_EMPTY;
					end else begin
						ctl.op    = sqs_pkg::OP_SHIFT_UP;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				sqs_pkg::KIND_PEEK: begin
					if (empty) o_stat = sqs_pkg::STAT_EMPTY;
					else       o_data = link[0].data;
				end
				sqs_pkg::KIND_DUMP: begin
					if (empty) begin
						o_stat = sqs_pkg::STAT_DUMP_EMPTY;
					end else begin
						ctl.op  = sqs_pkg::OP_ROTATE;
						o_data  = link[0].data;
						o_last  = (count_q == CNT_W'(1));
						rem_nxt = count_q - CNT_W'(1);
						if (count_q != CNT_W'(1)) state_nxt = ST_DUMP;
					end
				end
				default: ;
			endcase
		end else if (dump_step) begin
			ld      = 1'b1;
			ctl.op  = sqs_pkg::OP_ROTATE;
			o_data  = link[0].data;
			o_last  = (rem_q == CNT_W'(1));
			rem_nxt = rem_q - CNT_W'(1);
			if (rem_q == CNT_W'(1)) state_nxt = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rem_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			rem_q   <= rem_nxt;
			if (ld)             out_vld_q <= 1'b1;
			else if (out.ready) out_vld_q <= 1'b0;
		end
	end

	// result payload; held while the receiver stalls
	always_ff @(posedge clk) begin
		if (ld) begin
			out_data_q <= o_data;
			out_stat_q <= o_stat;
			out_last_q <= o_last;
		end
	end

	assign out.valid  = out_vld_q;
	assign out.data   = out_data_q;
	assign out.status = out_stat_q;
	assign out.last   = out_last_q;

	// the row of cells; cell 0 is the top
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sqs_pkg::cell_link_t up_l, dn_l;
		if (i == 0) begin : g_head
			assign up_l.valid = 1'b1;
			assign up_l.data  = in.value;
		end else begin : g_body
			assign up_l = link[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign dn_l.valid = 1'b0;
			assign dn_l.data  = '0;
		end else begin : g_next
			assign dn_l = link[i+1];
		end
		sqs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.up     (up_l),
			.dn     (dn_l),
			.cur    (link[i])
		);
		assign vld_vec[i] = link[i].valid;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_cells_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(count_q))
		else $error("occupied cells disagree with count");

	a_dump_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (!in.ready && rem_q != '0))
		else $error("input taken or empty remainder during dump");

	a_full_push_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == sqs_pkg::KIND_PUSH && full) |=> $stable(count_q))
		else $error("push into full store changed count");

	a_dump_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_step && rem_q == CNT_W'(1)) |=> (out.valid && out.last))
		else $error("final dump beat not marked last");
`endif

endmodule
